[hdl/planar_rle_image_decoder_unit_macros.svh]
// Assertion macros for the planar RLE decoder, used by prle_core.
// No dependencies; included by files that carry concurrent checks.
`ifndef PLANAR_RLE_IMAGE_DECODER_UNIT_MACROS_SVH
`define PLANAR_RLE_IMAGE_DECODER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PRLE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PRLE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/prle_pkg.sv]
// Package for the planar RLE decoder: field widths, constants, shared types.
// No dependencies.
package prle_pkg;

    localparam int CODE_W   = 8;
    localparam int PLANE_W  = 2;
    localparam int OFFS_W   = 16;
    localparam int LEN_W    = 8;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam int NUM_PLANES = 4;

    localparam logic [CODE_W-1:0] HEADER_SPLIT      = 8'd128;
    localparam logic [OFFS_W-1:0] PLANE_BYTES_RESET = 16'd28000;

    // register index, taken from paddr[2]
    localparam logic REG_PLANE_BYTES = 1'b0;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } beat_t;

endpackage

[hdl/planar_rle_image_decoder_unit.sv]
// Planar run-length image decoder, top level.
// Depends on prle_pkg, prle_cfg_regs, prle_in_stage, prle_core.
//
// Input channel s_*: one compressed byte (header, repeat value or literal) per beat.
// Result channel m_*: one write burst per beat (value, plane, start offset, length,
// done flag). Header bytes and bytes after image done produce no result beat.
// APB port: register 0 at address 0 is plane_bytes (16 bits, reset 28000);
// write it only while the block is idle.
// An accepted data byte goes to the input register, then the result register (m_valid).
// Throughput: one byte per cycle unless the receiver stalls, set by the input
// and result registers, with a single add/compare of the plane offset between them.
// Reset (aresetn, synchronous, active low) returns to header parsing at plane 0,
// offset 0, clears the finished flag and empties both stages.
// When the receiver stalls, the result beat holds; one more byte is taken into
// the input register, and headers keep flowing, before s_ready drops.
module planar_rle_image_decoder_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [prle_pkg::CODE_W-1:0]   s_code_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [prle_pkg::CODE_W-1:0]   m_pixel_value,
    output logic [prle_pkg::PLANE_W-1:0]  m_plane_index,
    output logic [prle_pkg::OFFS_W-1:0]   m_start_offset,
    output logic [prle_pkg::LEN_W-1:0]    m_run_length,
    output logic                          m_image_done,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prle_pkg::PADDR_W-1:0]  paddr,
    input  logic [prle_pkg::PDATA_W-1:0]  pwdata,
    output logic [prle_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import prle_pkg::*;

    logic [OFFS_W-1:0] plane_bytes;
    beat_t             item;
    logic              consume;

    prle_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .plane_bytes (plane_bytes)
    );

    prle_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_byte (s_code_byte),
        .consume     (consume),
        .item        (item)
    );

    prle_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item           (item),
        .consume        (consume),
        .plane_bytes    (plane_bytes),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_value  (m_pixel_value),
        .m_plane_index  (m_plane_index),
        .m_start_offset (m_start_offset),
        .m_run_length   (m_run_length),
        .m_image_done   (m_image_done)
    );

endmodule

[hdl/prle_cfg_regs.sv]
// APB-style configuration register file: holds plane_bytes.
// Depends on prle_pkg.
module prle_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prle_pkg::PADDR_W-1:0]  paddr,
    input  logic [prle_pkg::PDATA_W-1:0]  pwdata,
    output logic [prle_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [prle_pkg::OFFS_W-1:0]   plane_bytes
);
    import prle_pkg::*;

    logic [OFFS_W-1:0] plane_bytes_reg;
    logic              wr_en;
    logic              reg_idx;

    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_PLANE_BYTES);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_bytes_reg <= PLANE_BYTES_RESET;
        end else if (wr_en) begin
            plane_bytes_reg <= pwdata[OFFS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_PLANE_BYTES) begin
            prdata = {{(PDATA_W-OFFS_W){1'b0}}, plane_bytes_reg};
        end
    end

    assign plane_bytes = plane_bytes_reg;

endmodule

[hdl/prle_in_stage.sv]
// Input register stage: captures one compressed byte beat per cycle unless the core stalls.
// Depends on prle_pkg.
module prle_in_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [prle_pkg::CODE_W-1:0]  s_code_byte,
    input  logic                         consume,
    output prle_pkg::beat_t              item
);
    import prle_pkg::*;

    logic              valid_reg;
    logic [CODE_W-1:0] code_reg;

    assign s_ready = !valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            code_reg <= s_code_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.code  = code_reg;

endmodule

[hdl/prle_core.sv]
// Decode state and result register: header parsing, offset/plane tracking.
// Depends on prle_pkg and planar_rle_image_decoder_unit_macros.svh.
`include "planar_rle_image_decoder_unit_macros.svh"

module prle_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  prle_pkg::beat_t              item,
    output logic                         consume,
    input  logic [prle_pkg::OFFS_W-1:0]  plane_bytes,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [prle_pkg::CODE_W-1:0]  m_pixel_value,
    output logic [prle_pkg::PLANE_W-1:0] m_plane_index,
    output logic [prle_pkg::OFFS_W-1:0]  m_start_offset,
    output logic [prle_pkg::LEN_W-1:0]   m_run_length,
    output logic                         m_image_done
);
    import prle_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_REPEAT,
        PH_LITERAL
    } phase_t;

    phase_t             phase_reg,     phase_next;
    logic [LEN_W-1:0]   lit_left_reg,  lit_left_next;
    logic [LEN_W-1:0]   rep_cnt_reg,   rep_cnt_next;
    logic [PLANE_W-1:0] plane_reg,     plane_next;
    logic [OFFS_W-1:0]  offset_reg,    offset_next;
    logic               finished_reg,  finished_next;
    logic               m_valid_reg,   m_valid_next;
    logic [CODE_W-1:0]  pix_reg;
    logic [PLANE_W-1:0] pln_reg;
    logic [OFFS_W-1:0]  start_reg;
    logic [LEN_W-1:0]   len_reg,       len_next;
    logic               done_reg,      done_next;

    logic               emits;
    logic               out_space;
    logic               load;
    logic [LEN_W-1:0]   step_len;
    logic [OFFS_W:0]    off_sum;
    logic [OFFS_W-1:0]  off_sat;
    logic [OFFS_W-1:0]  limit;
    logic               close_grp;
    logic               last_plane;

    assign emits     = (phase_reg != PH_HEADER) && !finished_reg;
    assign out_space = !m_valid_reg || m_ready;
    assign consume   = item.valid && (!emits || out_space);
    assign load      = consume && emits;

    assign step_len   = (phase_reg == PH_REPEAT) ? rep_cnt_reg : LEN_W'(1);
    assign off_sum    = {1'b0, offset_reg} + (OFFS_W+1)'(step_len);
    assign off_sat    = off_sum[OFFS_W] ? {OFFS_W{1'b1}} : off_sum[OFFS_W-1:0];
    assign limit      = (plane_bytes == '0) ? OFFS_W'(1) : plane_bytes;
    assign last_plane = ({1'b0, plane_reg} + (PLANE_W+1)'(1)) >= (PLANE_W+1)'(NUM_PLANES);

    always_comb begin
        phase_next    = phase_reg;
        lit_left_next = lit_left_reg;
        rep_cnt_next  = rep_cnt_reg;
        plane_next    = plane_reg;
        offset_next   = offset_reg;
        finished_next = finished_reg;
        len_next      = LEN_W'(1);
        done_next     = 1'b0;
        close_grp     = 1'b0;
        if (consume && !finished_reg) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (item.code < HEADER_SPLIT) begin
                        rep_cnt_next = item.code + LEN_W'(1);
                        phase_next   = PH_REPEAT;
                    end else begin
                        lit_left_next = item.code - (HEADER_SPLIT - CODE_W'(1));
                        phase_next    = PH_LITERAL;
                    end
                end
                PH_REPEAT: begin
                    len_next     = rep_cnt_reg;
                    offset_next  = off_sat;
                    rep_cnt_next = '0;
                    close_grp    = 1'b1;
                end
                PH_LITERAL: begin
                    offset_next = off_sat;
                    if (lit_left_reg != '0) begin
                        lit_left_next = lit_left_reg - LEN_W'(1);
                    end
                    close_grp = (lit_left_reg <= LEN_W'(1));
                end
                default: begin
                    phase_next = PH_HEADER;
                end
            endcase
            if (close_grp) begin
                phase_next = PH_HEADER;
                if (off_sat >= limit) begin
                    offset_next = '0;
                    if (last_plane) begin
                        finished_next = 1'b1;
                        done_next     = 1'b1;
                    end else begin
                        plane_next = plane_reg + PLANE_W'(1);
                    end
                end
            end
        end
    end

    assign m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            lit_left_reg <= '0;
            rep_cnt_reg  <= '0;
            plane_reg    <= '0;
            offset_reg   <= '0;
            finished_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            lit_left_reg <= lit_left_next;
            rep_cnt_reg  <= rep_cnt_next;
            plane_reg    <= plane_next;
            offset_reg   <= offset_next;
            finished_reg <= finished_next;
            m_valid_reg  <= m_valid_next;
            if (load) begin
                pix_reg   <= item.code;
                pln_reg   <= plane_reg;
                start_reg <= offset_reg;
                len_reg   <= len_next;
                done_reg  <= done_next;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_value  = pix_reg;
    assign m_plane_index  = pln_reg;
    assign m_start_offset = start_reg;
    assign m_run_length   = len_reg;
    assign m_image_done   = done_reg;

    `PRLE_ASSERT_NEXT(a_finished_sticky, aclk, aresetn, finished_reg, finished_reg, "finished cleared")
    `PRLE_ASSERT_NEXT(a_done_sets_finished, aclk, aresetn, load && done_next, finished_reg, "done beat without finish")
    `PRLE_ASSERT_NEXT(a_no_beat_after_done, aclk, aresetn, finished_reg && !m_valid_reg, !m_valid_reg, "beat after image done")
    `PRLE_ASSERT_SAME(a_literal_count, aclk, aresetn, phase_reg == PH_LITERAL, lit_left_reg != '0, "literal phase with zero count")
    `PRLE_ASSERT_SAME(a_repeat_count, aclk, aresetn, phase_reg == PH_REPEAT, rep_cnt_reg != '0, "repeat phase with zero count")

endmodule

[tb/prle_burst_monitor.sv]
`timescale 1ns / 1ps
// Burst monitor for the planar RLE decoder: predicts write bursts from accepted
// code bytes and APB writes, compares each result beat. Depends on prle_pkg.
module prle_burst_monitor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [prle_pkg::CODE_W-1:0]   s_code_byte,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [prle_pkg::CODE_W-1:0]   m_pixel_value,
    input  logic [prle_pkg::PLANE_W-1:0]  m_plane_index,
    input  logic [prle_pkg::OFFS_W-1:0]   m_start_offset,
    input  logic [prle_pkg::LEN_W-1:0]    m_run_length,
    input  logic                          m_image_done,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [prle_pkg::PADDR_W-1:0]  paddr,
    input  logic [prle_pkg::PDATA_W-1:0]  pwdata,
    output int                            fail_count,
    output int                            waiting
);
    import prle_pkg::*;

    typedef enum logic [1:0] {WANT_HEADER, WANT_REPEAT, WANT_LITERAL} parse_t;

    typedef struct packed {
        logic [CODE_W-1:0]  value;
        logic [PLANE_W-1:0] plane;
        logic [OFFS_W-1:0]  offset;
        logic [LEN_W-1:0]   length;
        logic               done;
    } burst_t;

    burst_t             burst_q[$];
    parse_t             parse;
    logic [LEN_W-1:0]   lits_left;
    logic [LEN_W-1:0]   rep_cnt;
    logic [PLANE_W-1:0] cur_plane;
    logic [OFFS_W-1:0]  wr_offs;
    logic [OFFS_W-1:0]  plane_bytes;
    logic               img_done;

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s got %0d, predicted %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic decode_byte(input logic [CODE_W-1:0] b);
        logic [OFFS_W:0]   sum;
        logic [OFFS_W-1:0] lim;
        logic              close;
        burst_t            nb;
        if (img_done)
            return;
        if (parse == WANT_HEADER) begin
            if (b < HEADER_SPLIT) begin
                rep_cnt = b + 1'b1;
                parse   = WANT_REPEAT;
            end else begin
                lits_left = b - (HEADER_SPLIT - 1'b1);
                parse     = WANT_LITERAL;
            end
            return;
        end
        nb.value  = b;
        nb.plane  = cur_plane;
        nb.offset = wr_offs;
        nb.done   = 1'b0;
        if (parse == WANT_REPEAT) begin
            nb.length = rep_cnt;
            sum       = wr_offs + rep_cnt;
            close     = 1'b1;
        end else begin
            nb.length = LEN_W'(1);
            sum       = wr_offs + 1'b1;
            if (lits_left != '0)
                lits_left--;
            close = (lits_left == '0);
        end
        // offset saturates rather than wrapping
        wr_offs = sum[OFFS_W] ? {OFFS_W{1'b1}} : sum[OFFS_W-1:0];
        if (close) begin
            parse = WANT_HEADER;
            lim   = (plane_bytes == '0) ? OFFS_W'(1) : plane_bytes;
            if (wr_offs >= lim) begin
                wr_offs = '0;
                if (cur_plane == NUM_PLANES - 1) begin
                    img_done = 1'b1;
                    nb.done  = 1'b1;
                end else begin
                    cur_plane++;
                end
            end
        end
        burst_q.push_back(nb);
    endtask

    always @(posedge aclk) begin
        burst_t want;
        if (!aresetn) begin
            burst_q.delete();
            parse       = WANT_HEADER;
            lits_left   = '0;
            rep_cnt     = '0;
            cur_plane   = '0;
            wr_offs     = '0;
            plane_bytes = PLANE_BYTES_RESET;
            img_done    = 1'b0;
            fail_count  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (burst_q.size() == 0) begin
                    flag_mismatch("burst beat with nothing predicted, pixel_value", m_pixel_value, 0);
                end else begin
                    want = burst_q.pop_front();
                    if (m_pixel_value !== want.value)
                        flag_mismatch("pixel_value", m_pixel_value, want.value);
                    if (m_plane_index !== want.plane)
                        flag_mismatch("plane_index", m_plane_index, want.plane);
                    if (m_start_offset !== want.offset)
                        flag_mismatch("start_offset", m_start_offset, want.offset);
                    if (m_run_length !== want.length)
                        flag_mismatch("run_length", m_run_length, want.length);
                    if (m_image_done !== want.done)
                        flag_mismatch("image_done", m_image_done, want.done);
                end
            end
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_PLANE_BYTES)
                plane_bytes = pwdata[OFFS_W-1:0];
            if (s_valid && s_ready)
                decode_byte(s_code_byte);
        end
        waiting <= burst_q.size();
    end

endmodule

[tb/planar_rle_image_decoder_unit_test.sv]
`timescale 1ns / 1ps
// Top of the planar RLE decoder testbench: clock, reset, APB setup, code byte
// stimulus and receiver stalls. Depends on prle_pkg, prle_burst_monitor, the block.
module planar_rle_image_decoder_unit_test;
    import prle_pkg::*;

    localparam logic [PADDR_W-1:0] PLANE_BYTES_ADDR = 3'd0;
    localparam logic [PADDR_W-1:0] UNUSED_ADDR      = 3'd4;
    localparam int STALL_CYCLES = 300;
    localparam int QUIET_LIMIT  = 4000;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [CODE_W-1:0]  s_code_byte = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [CODE_W-1:0]  m_pixel_value;
    logic [PLANE_W-1:0] m_plane_index;
    logic [OFFS_W-1:0]  m_start_offset;
    logic [LEN_W-1:0]   m_run_length;
    logic               m_image_done;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int waiting;

    int s_idle_pct  = 37;
    int r_idle_pct  = 83;
    int hold_tag    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int quiet_cycles = 0;
    int n_sent      = 0;
    int fill_bytes  = 0;
    int planes_done = 0;
    logic [OFFS_W-1:0] size_now = PLANE_BYTES_RESET;

    always #5 aclk = ~aclk;

    planar_rle_image_decoder_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code_byte    (s_code_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_value  (m_pixel_value),
        .m_plane_index  (m_plane_index),
        .m_start_offset (m_start_offset),
        .m_run_length   (m_run_length),
        .m_image_done   (m_image_done),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    prle_burst_monitor u_mon (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code_byte    (s_code_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_value  (m_pixel_value),
        .m_plane_index  (m_plane_index),
        .m_start_offset (m_start_offset),
        .m_run_length   (m_run_length),
        .m_image_done   (m_image_done),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .fail_count     (fail_count),
        .waiting        (waiting)
    );

    // receiver: random back-pressure plus one long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_tag != hold_seen) begin
            hold_seen <= hold_tag;
            hold_left <= STALL_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= r_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_byte(input logic [CODE_W-1:0] b);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_code_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        n_sent++;
        if (n_sent == 280) begin
            s_idle_pct <= 83;
            r_idle_pct <= 37;
        end else if (n_sent == 560) begin
            s_idle_pct <= 0;
            r_idle_pct <= 0;
        end
    endtask

    // one header and its payload; tracks plane fill so the image ends on purpose
    task automatic send_group(input logic [CODE_W-1:0] hdr, input logic [31:0] pat,
                              input bit rnd);
        int n;
        send_byte(hdr);
        n = (hdr < HEADER_SPLIT) ? 1 : hdr - (HEADER_SPLIT - 1);
        for (int k = 0; k < n; k++)
            send_byte(rnd ? CODE_W'($urandom_range(255)) : pat[8*(k%4) +: 8]);
        fill_bytes += (hdr < HEADER_SPLIT) ? hdr + 1 : n;
        if (fill_bytes >= ((size_now == 0) ? 1 : size_now)) begin
            fill_bytes = 0;
            planes_done++;
        end
    endtask

    function automatic logic [CODE_W-1:0] pick_header();
        int r;
        r = $urandom_range(15);
        if (r < 8)
            return CODE_W'($urandom_range(127));
        else if (r < 15)
            return HEADER_SPLIT + CODE_W'($urandom_range(15));
        else
            return HEADER_SPLIT + CODE_W'($urandom_range(127));
    endfunction

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[PADDR_W-1:2] == REG_PLANE_BYTES)
            size_now = data[OFFS_W-1:0];
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (waiting != 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: shortest and longest repeat, short literal runs, edge values
        send_group(8'h00, 32'h0000_0000, 1'b0);
        send_group(8'h7F, 32'h0000_00FF, 1'b0);
        send_group(8'h80, 32'h0000_0080, 1'b0);
        send_group(8'h81, 32'h0000_017F, 1'b0);
        send_group(8'h01, 32'h0000_00AA, 1'b0);
        send_group(8'h83, 32'h00FF_AA55, 1'b0);
        settle();
        apb_write(UNUSED_ADDR, 32'h0000_0005);
        // upper data bits are dropped: plane size 6400
        apb_write(PLANE_BYTES_ADDR, 32'hFFFF_1900);

        // fill plane 0 mostly with long runs
        while (planes_done == 0)
            send_group(($urandom_range(7) != 0) ? 8'h7F : CODE_W'($urandom_range(255)),
                       32'h0, 1'b1);
        settle();
        apb_write(PLANE_BYTES_ADDR, 32'd65408);

        // mixed groups in plane 1 behind a long receiver hold
        hold_tag <= hold_tag + 1;
        send_group(8'hFF, 32'h0, 1'b1);
        repeat (30) send_group(pick_header(), 32'h0, 1'b1);
        settle();

        // shrink the plane mid-way, then a zero size
        apb_write(PLANE_BYTES_ADDR, 32'd1);
        send_group(pick_header(), 32'h0, 1'b1);
        settle();
        apb_write(PLANE_BYTES_ADDR, 32'd0);
        send_group(pick_header(), 32'h0, 1'b1);
        settle();
        apb_write(PLANE_BYTES_ADDR, 32'd200);
        while (planes_done < NUM_PLANES)
            send_group(pick_header(), 32'h0, 1'b1);

        // image is done: these bytes are dropped
        repeat (12) send_byte(CODE_W'($urandom_range(255)));
        settle();
        repeat (20) @(posedge aclk);

        if (fail_count == 0 && waiting == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[planar_rle_image_decoder_unit.f]
+incdir+hdl
hdl/prle_pkg.sv
hdl/prle_cfg_regs.sv
hdl/prle_in_stage.sv
hdl/prle_core.sv
hdl/planar_rle_image_decoder_unit.sv
tb/prle_burst_monitor.sv
tb/planar_rle_image_decoder_unit_test.sv
